FILE: hw/rtl/rse_pkg.sv
// ============================================================================
// rse_pkg: shared types and GF(256) helpers for the Reed-Solomon encoder
// Field polynomial x^8+x^4+x^3+x^2+1, primitive element alpha = 2. Holds the
// controller/datapath command and status structs and the alpha power table.
// ============================================================================
package rse_pkg;

    typedef logic [7:0] byte_t;
    typedef byte_t alpha_tab_t [256];

    // Low byte of the field polynomial, folded back in on carry out of bit 7
    localparam byte_t GF_POLY_LOW = 8'h1D;

    // Register index decode, taken from paddr[2]
    localparam logic IDX_PARITY_COUNT = 1'b0;
    localparam logic IDX_FIRST_ROOT   = 1'b1;

    // Reset values of the configuration registers
    localparam logic [5:0] PARITY_COUNT_RST = 6'd16;
    localparam logic [7:0] FIRST_ROOT_RST   = 8'd0;

    // Source of the output register payload
    typedef enum logic [1:0] {
        OSEL_ECHO   = 2'b00,
        OSEL_PARITY = 2'b01,
        OSEL_ERROR  = 2'b10
    } out_sel_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic     gen_init;     // generator := 1, alpha := alpha^first_root
        logic     gen_step;     // multiply generator by (x + alpha), alpha *= 2
        logic     par_clear;    // zero the parity register
        logic     par_shift;    // clock the division LFSR
        logic     par_zero_in;  // LFSR input is a padding zero
        logic     par_pop;      // shift parity bytes toward entry 0
        logic     out_load;     // load the output register
        out_sel_t out_sel;
        logic     out_run_end;
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic out_free;         // output register can take a new result this cycle
    } dp_status_t;

    // Multiply by alpha
    function automatic byte_t gf_xtime(input byte_t x);
        return {x[6:0], 1'b0} ^ (x[7] ? GF_POLY_LOW : 8'h00);
    endfunction

    // General GF(256) product, shift-and-add
    function automatic byte_t gf_mul(input byte_t a, input byte_t b);
        byte_t r;
        byte_t x;
        r = '0;
        x = a;
        for (int k = 0; k < 8; k++)
        begin
            if (b[k])
                r = r ^ x;
            x = gf_xtime(x);
        end
        return r;
    endfunction

    // alpha^e for e = 0..255, exponent taken modulo 255
    function automatic alpha_tab_t gf_alpha_table();
        alpha_tab_t t;
        byte_t      v;
        v = 8'h01;
        for (int e = 0; e < 255; e++)
        begin
            t[e] = v;
            v    = gf_xtime(v);
        end
        t[255] = 8'h01;
        return t;
    endfunction

    localparam alpha_tab_t ALPHA_POW = gf_alpha_table();

endpackage

FILE: hw/rtl/rse_ifs.sv
// ============================================================================
// rse_ifs: valid/ready stream interfaces of the Reed-Solomon encoder
// Message byte channel and encoded result channel.
// ============================================================================
interface rse_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface rse_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       is_parity;
    logic       run_end;
    logic       too_long;

    modport source (output valid, output out_byte, output is_parity, output run_end,
                    output too_long, input ready);
    modport sink   (input valid, input out_byte, input is_parity, input run_end,
                    input too_long, output ready);
endinterface

FILE: hw/rtl/rse_datapath.sv
// ============================================================================
// rse_datapath: generator builder, division LFSR and output register
// All GF lanes work in parallel, one generator step or one LFSR shift a cycle.
// ============================================================================
module rse_datapath #(
    parameter int MAX_PARITY = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  rse_pkg::dp_cmd_t    cmd,
    input  logic [7:0]          in_byte,
    input  logic [7:0]          first_root,
    output rse_pkg::dp_status_t status,
    rse_out_if.source           res
);
    import rse_pkg::*;

    byte_t gen_reg  [MAX_PARITY+1];
    byte_t gen_next [MAX_PARITY+1];
    byte_t par_reg  [MAX_PARITY];
    byte_t par_ext  [MAX_PARITY+1];
    byte_t shift_val[MAX_PARITY];
    byte_t alpha_reg;
    byte_t fb;

    logic  out_valid_reg;
    byte_t out_byte_reg;
    logic  is_parity_reg;
    logic  run_end_reg;
    logic  too_long_reg;

    // Parity register padded with a zero above the top entry
    always_comb
    begin
        for (int j = 0; j < MAX_PARITY; j++)
            par_ext[j] = par_reg[j];
        par_ext[MAX_PARITY] = 8'h00;
    end

    // LFSR next value; entries above T stay zero because g[j] = 0 for j > T
    always_comb
    begin
        fb = (cmd.par_zero_in ? 8'h00 : in_byte) ^ par_reg[0];
        for (int j = 0; j < MAX_PARITY; j++)
            shift_val[j] = par_ext[j+1] ^ gf_mul(fb, gen_reg[j+1]);
    end

    // Generator step: g(x) * (x + alpha), all coefficients from old values
    always_comb
    begin
        gen_next[0] = gen_reg[0];
        for (int j = 1; j <= MAX_PARITY; j++)
            gen_next[j] = gen_reg[j] ^ gf_mul(gen_reg[j-1], alpha_reg);
    end

    // Generator coefficients and running root
    always_ff @(posedge clk)
    begin
        if (cmd.gen_init)
        begin
            gen_reg[0] <= 8'h01;
            for (int j = 1; j <= MAX_PARITY; j++)
                gen_reg[j] <= 8'h00;
            alpha_reg <= ALPHA_POW[first_root];
        end
        else if (cmd.gen_step)
        begin
            gen_reg   <= gen_next;
            alpha_reg <= gf_xtime(alpha_reg);
        end
    end

    // Parity register: clear, shift a byte in, or pop toward entry 0
    always_ff @(posedge clk)
    begin
        if (cmd.par_clear)
        begin
            for (int j = 0; j < MAX_PARITY; j++)
                par_reg[j] <= 8'h00;
        end
        else if (cmd.par_shift)
        begin
            par_reg <= shift_val;
        end
        else if (cmd.par_pop)
        begin
            for (int j = 0; j < MAX_PARITY; j++)
                par_reg[j] <= par_ext[j+1];
        end
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (res.ready)
            out_valid_reg <= 1'b0;
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            run_end_reg <= cmd.out_run_end;
            case (cmd.out_sel)
                OSEL_ECHO:
                begin
                    out_byte_reg  <= in_byte;
                    is_parity_reg <= 1'b0;
                    too_long_reg  <= 1'b0;
                end
                OSEL_PARITY:
                begin
                    out_byte_reg  <= par_reg[0];
                    is_parity_reg <= 1'b1;
                    too_long_reg  <= 1'b0;
                end
                OSEL_ERROR:
                begin
                    out_byte_reg  <= 8'h00;
                    is_parity_reg <= 1'b0;
                    too_long_reg  <= 1'b1;
                end
                default:
                begin
                    out_byte_reg  <= 8'h00;
                    is_parity_reg <= 1'b0;
                    too_long_reg  <= 1'b0;
                end
            endcase
        end
    end

    assign res.valid     = out_valid_reg;
    assign res.out_byte  = out_byte_reg;
    assign res.is_parity = is_parity_reg;
    assign res.run_end   = run_end_reg;
    assign res.too_long  = too_long_reg;

    assign status.out_free = !out_valid_reg || res.ready;

endmodule

FILE: hw/rtl/rse_ctrl.sv
// ============================================================================
// rse_ctrl: encoder sequencer
// Builds the generator, counts message bytes, runs the zero padding, emits
// the parity bytes and handles over-long blocks.
// ============================================================================
module rse_ctrl #(
    parameter int BLOCK_LEN  = 255,
    parameter int MAX_PARITY = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr,
    input  logic [5:0]          parity_count,
    input  logic                in_valid,
    input  logic                in_last,
    output logic                in_ready,
    input  rse_pkg::dp_status_t status,
    output rse_pkg::dp_cmd_t    cmd
);
    import rse_pkg::*;

    localparam int TW   = $clog2(MAX_PARITY + 1);
    localparam int CW   = $clog2(BLOCK_LEN + 1);
    localparam int TLIM = (MAX_PARITY < BLOCK_LEN - 1) ? MAX_PARITY : BLOCK_LEN - 1;

    typedef enum logic [4:0] {
        S_BUILD_INIT = 5'b00001,
        S_BUILD      = 5'b00010,
        S_RUN        = 5'b00100,
        S_PAD        = 5'b01000,
        S_EMIT       = 5'b10000
    } state_t;

    state_t          state_reg, state_next;
    logic [TW-1:0]   t_reg, t_next;
    logic [TW-1:0]   idx_reg, idx_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            ovf_reg, ovf_next;
    logic            dirty_reg, dirty_next;

    logic [6:0]      pc_w;
    logic [6:0]      t_w;
    logic [TW-1:0]   eff_t;
    logic [TW-1:0]   t_last;
    logic [CW-1:0]   msg_max;
    logic [CW-1:0]   cnt_inc;
    logic            boundary;
    logic            over;
    logic            in_fire;

    // Effective parity count: zero reads as one, large values saturate
    always_comb
    begin
        pc_w = {1'b0, parity_count};
        if (pc_w == 7'd0)
            t_w = 7'd1;
        else if (pc_w > 7'(TLIM))
            t_w = 7'(TLIM);
        else
            t_w = pc_w;
        eff_t = TW'(t_w);
    end

    assign t_last   = t_reg - 1'b1;
    assign msg_max  = CW'(BLOCK_LEN) - CW'(t_reg);
    assign cnt_inc  = cnt_reg + 1'b1;
    assign boundary = (cnt_reg == '0) && !ovf_reg;
    assign over     = ovf_reg || (cnt_reg >= msg_max);

    // Take bytes only in RUN with room in the output register; a pending
    // config change rebuilds the generator first at a block boundary
    assign in_ready = (state_reg == S_RUN) && !(boundary && dirty_reg) && status.out_free;
    assign in_fire  = in_valid && in_ready;

    // Next-state and command logic
    always_comb
    begin
        state_next = state_reg;
        t_next     = t_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        ovf_next   = ovf_reg;
        dirty_next = dirty_reg || cfg_wr;
        cmd        = '0;
        cmd.out_sel = OSEL_ECHO;

        case (state_reg)
            S_BUILD_INIT:
            begin
                cmd.gen_init  = 1'b1;
                cmd.par_clear = 1'b1;
                t_next        = eff_t;
                idx_next      = '0;
                cnt_next      = '0;
                ovf_next      = 1'b0;
                dirty_next    = cfg_wr;
                state_next    = S_BUILD;
            end

            S_BUILD:
            begin
                cmd.gen_step = 1'b1;
                idx_next     = idx_reg + 1'b1;
                if (idx_reg == t_last)
                begin
                    idx_next   = '0;
                    state_next = S_RUN;
                end
            end

            S_RUN:
            begin
                if (boundary && dirty_reg)
                begin
                    state_next = S_BUILD_INIT;
                end
                else if (in_fire)
                begin
                    if (over)
                    begin
                        // Over-long block: drop bytes, one error result on last
                        ovf_next = 1'b1;
                        if (in_last)
                        begin
                            cmd.out_load    = 1'b1;
                            cmd.out_sel     = OSEL_ERROR;
                            cmd.out_run_end = 1'b1;
                            cmd.par_clear   = 1'b1;
                            cnt_next        = '0;
                            ovf_next        = 1'b0;
                        end
                    end
                    else
                    begin
                        cmd.out_load  = 1'b1;
                        cmd.out_sel   = OSEL_ECHO;
                        cmd.par_shift = 1'b1;
                        cnt_next      = cnt_inc;
                        if (in_last)
                        begin
                            idx_next = '0;
                            if (cnt_inc == msg_max)
                                state_next = S_EMIT;
                            else
                                state_next = S_PAD;
                        end
                    end
                end
            end

            S_PAD:
            begin
                cmd.par_shift   = 1'b1;
                cmd.par_zero_in = 1'b1;
                cnt_next        = cnt_inc;
                if (cnt_inc == msg_max)
                    state_next = S_EMIT;
            end

            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load    = 1'b1;
                    cmd.out_sel     = OSEL_PARITY;
                    cmd.par_pop     = 1'b1;
                    cmd.out_run_end = (idx_reg == t_last);
                    idx_next        = idx_reg + 1'b1;
                    if (idx_reg == t_last)
                    begin
                        idx_next   = '0;
                        cnt_next   = '0;
                        ovf_next   = 1'b0;
                        state_next = S_RUN;
                    end
                end
            end

            default:
            begin
                state_next = S_BUILD_INIT;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_BUILD_INIT;
            t_reg     <= TW'(1);
            idx_reg   <= '0;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
            dirty_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            t_reg     <= t_next;
            idx_reg   <= idx_next;
            cnt_reg   <= cnt_next;
            ovf_reg   <= ovf_next;
            dirty_reg <= dirty_next;
        end
    end

endmodule

FILE: hw/rtl/reed_solomon_systematic_encoder_core.sv
// ============================================================================
// reed_solomon_systematic_encoder_core: systematic RS encoder over GF(256)
// Message bytes in on msg, echoed bytes then T parity bytes out on enc.
//
// Usage:
// - msg carries one message byte per transfer, first byte highest degree;
//   last marks the final byte of a block.
// - enc returns each byte echoed, then the T parity bytes with is_parity set,
//   the final one with run_end. A block longer than BLOCK_LEN-T bytes gives a
//   single too_long result on its last byte and no parity.
// - Registered: a result is shown in the cycle after the transfer causing it.
// - Throughput: one message byte a cycle while enc keeps up. After the last
//   byte the division LFSR is clocked with zero padding up to BLOCK_LEN-T
//   bytes, then the T parity bytes follow, one a cycle while enc keeps up;
//   msg is held off meanwhile.
// - The generator is rebuilt after reset, and at the first block boundary
//   after a config write; msg is held off meanwhile.
// - A single output register decouples the sides; when enc stalls, msg is
//   held off until the waiting result is taken.
// - Config (APB): parity_count at 0x0, first_root at 0x4; pready always high.
// ============================================================================
module reed_solomon_systematic_encoder_core #(
    parameter int BLOCK_LEN  = 255,
    parameter int MAX_PARITY = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    rse_in_if.sink      msg,
    rse_out_if.source   enc
);
    import rse_pkg::*;

    logic [5:0] parity_count_reg;
    logic [7:0] first_root_reg;
    logic       cfg_wr;
    logic       in_ready;
    dp_cmd_t    cmd;
    dp_status_t status;

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parity_count_reg <= PARITY_COUNT_RST;
            first_root_reg   <= FIRST_ROOT_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                IDX_PARITY_COUNT: parity_count_reg <= pwdata[5:0];
                IDX_FIRST_ROOT:   first_root_reg   <= pwdata[7:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            IDX_PARITY_COUNT: prdata = {26'd0, parity_count_reg};
            IDX_FIRST_ROOT:   prdata = {24'd0, first_root_reg};
            default:          prdata = '0;
        endcase
    end

    // Sequencer
    rse_ctrl #(
        .BLOCK_LEN  (BLOCK_LEN),
        .MAX_PARITY (MAX_PARITY)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr       (cfg_wr),
        .parity_count (parity_count_reg),
        .in_valid     (msg.valid),
        .in_last      (msg.last),
        .in_ready     (in_ready),
        .status       (status),
        .cmd          (cmd)
    );

    assign msg.ready = in_ready;

    // GF datapath and output register
    rse_datapath #(
        .MAX_PARITY (MAX_PARITY)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .in_byte    (msg.data_byte),
        .first_root (first_root_reg),
        .status     (status),
        .res        (enc)
    );

    // Input is only taken when the output register has room
    a_ready_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        msg.ready |-> !(enc.valid && !enc.ready))
        else $error("input ready while a stalled result is held");

    // An error result is a lone zero byte that closes the block
    a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (enc.valid && enc.too_long) |-> (enc.run_end && !enc.is_parity && enc.out_byte == 8'h00))
        else $error("malformed too_long result");

    // No message byte is taken while parity bytes remain to be sent
    a_no_input_in_parity: assert property (@(posedge clk) disable iff (!rst_n)
        (enc.valid && enc.is_parity && !enc.run_end) |-> !msg.ready)
        else $error("input accepted during parity emission");

endmodule

FILE: dv/tb_top.sv
// ============================================================================
// tb_top: testbench of the systematic Reed-Solomon encoder core
// Drives message blocks over the msg stream and checks every echoed byte,
// parity byte and too_long result against an in-bench GF(256) encoder model.
// A directed plan with hand-read results comes first. Random blocks follow
// under random parity counts and first roots, with random idling on both sides.
// ============================================================================
module tb_top;
    import rse_pkg::*;

    localparam int unsigned BLOCK_N     = 255;
    localparam int unsigned MAX_T       = 32;
    localparam int unsigned RAND_TARGET = 16;
    localparam int unsigned SETTLE      = 8;
    localparam int unsigned LONG_HOLD   = 300;
    localparam int unsigned CYCLE_LIMIT = 3000000;
    localparam int unsigned MAX_REPORTS = 20;
    localparam byte_t       FIELD_TAIL  = 8'h1D;

    // One encoder result as seen on enc
    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_parity;
        logic       run_end;
        logic       too_long;
    } enc_word_t;

    // Idle pacing of one side
    typedef enum int unsigned {
        PACE_RANDOM,
        PACE_NONE,
        PACE_LIGHT
    } pace_t;

    // Directed plan rows
    typedef enum logic {
        ROW_WRITE,
        ROW_BYTE
    } row_kind_t;

    typedef struct packed {
        row_kind_t  kind;
        logic       idx;
        logic [31:0] value;
        logic       lst;
        logic       typed;
        enc_word_t  want;
    } plan_row_t;

    localparam enc_word_t NO_WORD = '0;
    localparam int PLAN_LEN = 27;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    rse_in_if  msg_if();
    rse_out_if enc_if();

    reed_solomon_systematic_encoder_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .msg     (msg_if),
        .enc     (enc_if)
    );

    // Encoder model state
    byte_t       gen_poly [0:MAX_T];
    byte_t       rem_reg [0:MAX_T-1];
    int unsigned msg_count;
    bit          dropping;
    int unsigned blk_t;
    logic [5:0]  cfg_t;
    logic [7:0]  cfg_root;

    enc_word_t   pending_words [$];
    int unsigned fail_count;
    int unsigned cycles;
    int unsigned send_pace;
    int unsigned recv_pace;
    int unsigned hold_req;

    plan_row_t plan [PLAN_LEN] = '{
        // after reset: T=16, first root 0
        '{ROW_BYTE,  IDX_PARITY_COUNT, 32'h00, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0}},
        '{ROW_BYTE,  IDX_PARITY_COUNT, 32'hFF, 1'b0, 1'b1, '{8'hFF, 1'b0, 1'b0, 1'b0}},
        '{ROW_BYTE,  IDX_PARITY_COUNT, 32'h80, 1'b0, 1'b0, NO_WORD},
        '{ROW_BYTE,  IDX_PARITY_COUNT, 32'h01, 1'b1, 1'b0, NO_WORD},
        // zero parity count is taken as one
        '{ROW_WRITE, IDX_PARITY_COUNT, 32'd0,   1'b0, 1'b0, NO_WORD},
        '{ROW_WRITE, IDX_FIRST_ROOT,   32'd254, 1'b0, 1'b0, NO_WORD},
        '{ROW_BYTE,  IDX_PARITY_COUNT, 32'hFF, 1'b0, 1'b1, '{8'hFF, 1'b0, 1'b0, 1'b0}},
        '{ROW_BYTE,  IDX_PARITY_COUNT, 32'h5A, 1'b1, 1'b0, NO_WORD},
        // all-ones parity count saturates, root exponent wraps
        '{ROW_WRITE, IDX_PARITY_COUNT, 32'd63,  1'b0, 1'b0, NO_WORD},
        '{ROW_WRITE, IDX_FIRST_ROOT,   32'd255, 1'b0, 1'b0, NO_WORD},
        '{ROW_BYTE,  IDX_PARITY_COUNT, 32'h00, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0}},
        '{ROW_BYTE,  IDX_PARITY_COUNT, 32'hFF, 1'b1, 1'b0, NO_WORD},
        // just above the parity limit
        '{ROW_WRITE, IDX_PARITY_COUNT, 32'd33,  1'b0, 1'b0, NO_WORD},
        '{ROW_WRITE, IDX_FIRST_ROOT,   32'd0,   1'b0, 1'b0, NO_WORD},
        '{ROW_BYTE,  IDX_PARITY_COUNT, 32'hC3, 1'b1, 1'b0, NO_WORD},
        // single parity byte
        '{ROW_WRITE, IDX_PARITY_COUNT, 32'd1,   1'b0, 1'b0, NO_WORD},
        '{ROW_BYTE,  IDX_PARITY_COUNT, 32'h01, 1'b0, 1'b0, NO_WORD},
        '{ROW_BYTE,  IDX_PARITY_COUNT, 32'h02, 1'b0, 1'b0, NO_WORD},
        '{ROW_BYTE,  IDX_PARITY_COUNT, 32'h03, 1'b1, 1'b0, NO_WORD},
        '{ROW_WRITE, IDX_PARITY_COUNT, 32'd2,   1'b0, 1'b0, NO_WORD},
        '{ROW_WRITE, IDX_FIRST_ROOT,   32'd1,   1'b0, 1'b0, NO_WORD},
        '{ROW_BYTE,  IDX_PARITY_COUNT, 32'h55, 1'b0, 1'b0, NO_WORD},
        '{ROW_BYTE,  IDX_PARITY_COUNT, 32'hAA, 1'b1, 1'b0, NO_WORD},
        // max parity, two blocks back to back
        '{ROW_WRITE, IDX_PARITY_COUNT, 32'd32,  1'b0, 1'b0, NO_WORD},
        '{ROW_WRITE, IDX_FIRST_ROOT,   32'd120, 1'b0, 1'b0, NO_WORD},
        '{ROW_BYTE,  IDX_PARITY_COUNT, 32'h7E, 1'b1, 1'b0, NO_WORD},
        '{ROW_BYTE,  IDX_PARITY_COUNT, 32'h00, 1'b1, 1'b0, NO_WORD}
    };

    // GF(256) product, Horner form over the bits of b
    function automatic byte_t gf_times(input byte_t a, input byte_t b);
        byte_t acc;
        acc = 8'h00;
        for (int i = 7; i >= 0; i--)
        begin
            acc = {acc[6:0], 1'b0} ^ (acc[7] ? FIELD_TAIL : 8'h00);
            if (b[i])
                acc = acc ^ a;
        end
        return acc;
    endfunction

    function automatic byte_t alpha_exp(input int unsigned e);
        byte_t r;
        r = 8'h01;
        for (int unsigned k = 0; k < e % 255; k++)
            r = gf_times(r, 8'h02);
        return r;
    endfunction

    function automatic int unsigned clamp_parity(input logic [5:0] t);
        if (t == 0)
            return 1;
        if (t > MAX_T)
            return MAX_T;
        return t;
    endfunction

    function automatic int unsigned draw_wait(input int unsigned pace);
        case (pace)
            PACE_RANDOM: return $urandom_range(16, 0);
            PACE_LIGHT:  return $urandom_range(2, 0);
            default:     return 0;
        endcase
    endfunction

    // Latch T and build g(x) = prod (x + alpha^(i+root)) at a block start
    task automatic open_block();
        byte_t a;
        blk_t = clamp_parity(cfg_t);
        foreach (gen_poly[j])
            gen_poly[j] = 8'h00;
        gen_poly[0] = 8'h01;
        for (int unsigned i = 0; i < blk_t; i++)
        begin
            a = alpha_exp(i + cfg_root);
            for (int unsigned j = i + 1; j >= 1; j--)
                gen_poly[j] = gen_poly[j] ^ gf_times(gen_poly[j-1], a);
        end
        foreach (rem_reg[j])
            rem_reg[j] = 8'h00;
        msg_count = 0;
        dropping  = 1'b0;
    endtask

    // One clock of the division LFSR
    task automatic clock_remainder(input byte_t din);
        byte_t fb;
        fb = din ^ rem_reg[0];
        for (int unsigned j = 0; j + 1 < blk_t; j++)
            rem_reg[j] = rem_reg[j+1] ^ gf_times(fb, gen_poly[j+1]);
        rem_reg[blk_t-1] = gf_times(fb, gen_poly[blk_t]);
    endtask

    // Expected results of one accepted message byte
    task automatic predict_transfer(input byte_t d, input bit lst, input bit typed,
                                    input enc_word_t typed_w, output int unsigned n_out);
        enc_word_t   got [$];
        int unsigned msg_max;
        if (msg_count == 0 && !dropping)
            open_block();
        msg_max = BLOCK_N - blk_t;
        if (dropping || msg_count >= msg_max)
        begin
            // over-long block: silent drops, one error result on the last byte
            dropping = 1'b1;
            if (lst)
            begin
                got.push_back('{8'h00, 1'b0, 1'b1, 1'b1});
                foreach (rem_reg[j])
                    rem_reg[j] = 8'h00;
                msg_count = 0;
                dropping  = 1'b0;
            end
        end
        else
        begin
            got.push_back('{d, 1'b0, 1'b0, 1'b0});
            clock_remainder(d);
            msg_count++;
            if (lst)
            begin
                // zero padding up to N-T, then the T parity bytes
                while (msg_count < msg_max)
                begin
                    clock_remainder(8'h00);
                    msg_count++;
                end
                for (int unsigned j = 0; j < blk_t; j++)
                    got.push_back('{rem_reg[j], 1'b1, (j + 1 == blk_t), 1'b0});
                foreach (rem_reg[j])
                    rem_reg[j] = 8'h00;
                msg_count = 0;
                dropping  = 1'b0;
            end
        end
        if (typed && got.size() > 0)
            got[0] = typed_w;
        foreach (got[k])
            pending_words.push_back(got[k]);
        n_out = got.size();
    endtask

    // Offer one byte on msg and wait for its transfer
    task automatic send_byte(input byte_t d, input bit lst, input bit typed,
                             input enc_word_t typed_w, output int unsigned n_out);
        int unsigned gap;
        gap = draw_wait(send_pace);
        if (gap != 0)
        begin
            msg_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        msg_if.valid     <= 1'b1;
        msg_if.data_byte <= d;
        msg_if.last      <= lst;
        do
            @(posedge clk);
        while (!msg_if.ready);
        predict_transfer(d, lst, typed, typed_w, n_out);
    endtask

    // Stop offering and let every expected result drain
    task automatic drain_results();
        msg_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_words.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    // One APB transfer; returns prdata of the access phase
    task automatic apb_xfer(input bit wr, input logic idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic report(input string what, input int unsigned want, input int unsigned got);
        if (fail_count < MAX_REPORTS)
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
        fail_count++;
    endtask

    // Read back a register against the model copy
    task automatic check_reg(input logic idx);
        logic [31:0] rd;
        apb_xfer(1'b0, idx, 32'h0, rd);
        if (idx == IDX_PARITY_COUNT)
        begin
            if (rd[5:0] !== cfg_t)
                report("parity_count read", cfg_t, rd[5:0]);
        end
        else if (rd[7:0] !== cfg_root)
            report("first_root read", cfg_root, rd[7:0]);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        logic [31:0] unused;
        apb_xfer(1'b1, idx, val, unused);
        if (idx == IDX_PARITY_COUNT)
            cfg_t = val[5:0];
        else
            cfg_root = val[7:0];
        check_reg(idx);
    endtask

    function automatic byte_t pick_byte();
        if ($urandom_range(7, 0) == 0)
            return $urandom_range(1, 0) ? 8'hFF : 8'h00;
        return byte_t'($urandom_range(255, 0));
    endfunction

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // Result receiver: random stalls, one long hold on request, checks each transfer
    initial
    begin
        int unsigned stall;
        enc_word_t   want;
        enc_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req != 0)
            begin
                stall    = hold_req;
                hold_req = 0;
            end
            else
                stall = draw_wait(recv_pace);
            if (stall != 0)
            begin
                enc_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            enc_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (!enc_if.valid);
            if (pending_words.size() == 0)
            begin
                if (fail_count < MAX_REPORTS)
                    $display("%0t: unexpected result: expected none, actual %0h/%b%b%b",
                             $time, enc_if.out_byte, enc_if.is_parity, enc_if.run_end,
                             enc_if.too_long);
                fail_count++;
            end
            else
            begin
                want = pending_words.pop_front();
                if (enc_if.out_byte !== want.out_byte)
                    report("out_byte", want.out_byte, enc_if.out_byte);
                if (enc_if.is_parity !== want.is_parity)
                    report("is_parity", want.is_parity, enc_if.is_parity);
                if (enc_if.run_end !== want.run_end)
                    report("run_end", want.run_end, enc_if.run_end);
                if (enc_if.too_long !== want.too_long)
                    report("too_long", want.too_long, enc_if.too_long);
            end
        end
    end

    // Stimulus
    initial
    begin
        int unsigned n_out;
        int unsigned rand_items;
        int unsigned phase_no;
        int unsigned blocks;
        int unsigned len;
        int unsigned msg_max;
        int unsigned pick;
        logic [31:0] t_val;
        logic [31:0] root_val;

        rst_n            <= 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        msg_if.valid     <= 1'b0;
        msg_if.data_byte <= '0;
        msg_if.last      <= 1'b0;
        fail_count = 0;
        hold_req   = 0;
        send_pace  = PACE_RANDOM;
        recv_pace  = PACE_RANDOM;
        cfg_t      = PARITY_COUNT_RST;
        cfg_root   = FIRST_ROOT_RST;
        open_block();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values
        check_reg(IDX_PARITY_COUNT);
        check_reg(IDX_FIRST_ROOT);

        // directed plan
        for (int r = 0; r < PLAN_LEN; r++)
        begin
            if (plan[r].kind == ROW_WRITE)
            begin
                drain_results();
                write_reg(plan[r].idx, plan[r].value);
            end
            else
                send_byte(plan[r].value[7:0], plan[r].lst, plan[r].typed, plan[r].want,
                          n_out);
        end

        // full-length block with no padding, then an over-long block, at max T
        drain_results();
        write_reg(IDX_PARITY_COUNT, $urandom_range(63, 32));
        write_reg(IDX_FIRST_ROOT, $urandom_range(255, 0));
        send_pace = PACE_NONE;
        recv_pace = PACE_LIGHT;
        msg_max   = BLOCK_N - clamp_parity(cfg_t);
        for (int unsigned k = 0; k < msg_max; k++)
            send_byte(pick_byte(), k + 1 == msg_max, 1'b0, NO_WORD, n_out);
        len = msg_max + $urandom_range(4, 1);
        for (int unsigned k = 0; k < len; k++)
            send_byte(pick_byte(), k + 1 == len, 1'b0, NO_WORD, n_out);

        // random short blocks over random settings
        rand_items = 0;
        phase_no   = 0;
        while (rand_items < RAND_TARGET)
        begin
            drain_results();
            pick = $urandom_range(9, 0);
            case (pick)
                0:       t_val = 0;
                1:       t_val = $urandom_range(63, 33);
                2:       t_val = MAX_T;
                3:       t_val = 1;
                default: t_val = $urandom_range(MAX_T, 1);
            endcase
            pick = $urandom_range(7, 0);
            case (pick)
                0:       root_val = 0;
                1:       root_val = 255;
                2:       root_val = 254;
                default: root_val = $urandom_range(255, 0);
            endcase
            write_reg(IDX_PARITY_COUNT, t_val);
            write_reg(IDX_FIRST_ROOT, root_val);
            send_pace = $urandom_range(PACE_LIGHT, PACE_RANDOM);
            recv_pace = $urandom_range(PACE_LIGHT, PACE_RANDOM);
            // one phase with a long receiver hold while bytes keep coming
            if (phase_no == 0)
            begin
                send_pace = PACE_NONE;
                hold_req  = LONG_HOLD;
            end
            blocks = $urandom_range(6, 2);
            for (int unsigned b = 0; b < blocks; b++)
            begin
                len = ($urandom_range(7, 0) == 0) ? $urandom_range(40, 13)
                                                  : $urandom_range(12, 1);
                for (int unsigned k = 0; k < len; k++)
                begin
                    send_byte(pick_byte(), k + 1 == len, 1'b0, NO_WORD, n_out);
                    if (n_out != 0)
                        rand_items++;
                end
            end
            phase_no++;
        end

        // wind down
        drain_results();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
